// ===== rtl/ckle_pkg.sv =====
`timescale 1ns / 1ps
package ckle_pkg;

    localparam int NODE_SLOTS = 16;
    localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
    localparam int KEY_W      = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int ENTRIES_W  = 5;
    localparam int WIDE_W     = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;
    localparam int NODE_W     = KEY_W + SLOT_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_LINK,
        S_ADD_HEAD,
        S_WALK,
        S_LAST
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic        [SLOT_W-1:0] link;
    } t_node;

endpackage

// ===== rtl/ckle_ram.sv =====
`timescale 1ns / 1ps
module ckle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// ===== rtl/circular_key_list_engine.sv =====
`timescale 1ns / 1ps
// Circular list of signed keys held in a single node memory (key and link per
// slot) with a free map in flip-flops. A transaction is taken when start is
// high and busy is low; its result appears on o_status and o_entries for
// exactly one cycle with o_strobe, and the receiver cannot stall it, so it
// must take every strobed result. Clear, the unused code, an add to a full
// store and a delete on an empty list give their result in the cycle after
// start without raising busy; an add to an empty list does the same. An add
// to a non-empty list reads the head, writes the new node, then relinks the
// head. A delete reads one node per cycle from the head until a match or
// until the walk comes back to the head (a miss); removing the head of a
// list with more than one node walks on to the last node to relink it. The
// node memory has a single read port, walked one link per cycle.
module circular_key_list_engine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ckle_pkg::OP_W-1:0]             i_operation,
    input  logic signed [ckle_pkg::KEY_W-1:0]     i_key,
    output logic                                  o_strobe,
    output logic [ckle_pkg::STATUS_W-1:0]         o_status,
    output logic [ckle_pkg::ENTRIES_W-1:0]        o_entries
);

    ckle_pkg::t_state                      r_state, n_state;
    logic [ckle_pkg::NODE_SLOTS-1:0]       r_free, n_free;
    logic [ckle_pkg::SLOT_W-1:0]           r_head, n_head;
    logic                                  r_empty, n_empty;
    logic [ckle_pkg::CNT_W-1:0]            r_count, n_count;
    logic signed [ckle_pkg::KEY_W-1:0]     r_key, n_key;
    logic [ckle_pkg::SLOT_W-1:0]           r_slot, n_slot;
    logic [ckle_pkg::SLOT_W-1:0]           r_cur, n_cur;
    logic [ckle_pkg::SLOT_W-1:0]           r_before, n_before;
    logic signed [ckle_pkg::KEY_W-1:0]     r_prev_key, n_prev_key;
    logic [ckle_pkg::SLOT_W-1:0]           r_nxt, n_nxt;
    logic                                  r_strobe, n_strobe;
    ckle_pkg::t_status                     r_status, n_status;
    logic [ckle_pkg::ENTRIES_W-1:0]        r_entries;

    logic [ckle_pkg::SLOT_W-1:0]           w_free_slot;
    logic [ckle_pkg::WIDE_W-1:0]           w_count_wide;
    logic                                  w_we;
    logic [ckle_pkg::SLOT_W-1:0]           w_wr_addr;
    logic [ckle_pkg::SLOT_W-1:0]           w_rd_addr;
    ckle_pkg::t_node                       w_wr_node;
    ckle_pkg::t_node                       w_rd_node;
    logic [ckle_pkg::NODE_W-1:0]           w_rd_data;

    function automatic logic [ckle_pkg::SLOT_W-1:0] f_lowest(
        input logic [ckle_pkg::NODE_SLOTS-1:0] v
    );
        logic [ckle_pkg::SLOT_W-1:0] s;
        s = '0;
        for (int i = ckle_pkg::NODE_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                s = ckle_pkg::SLOT_W'(i);
            end
        end
        return s;
    endfunction

    assign w_free_slot = f_lowest(r_free);
    assign w_rd_node   = ckle_pkg::t_node'(w_rd_data);

    // Every write lands before any later read of that node whose data is used,
    // because each state issues its reads only after the previous write.
    ckle_ram #(
        .WIDTH (ckle_pkg::NODE_W),
        .DEPTH (ckle_pkg::NODE_SLOTS)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_node),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ckle_pkg::S_IDLE;
            r_free   <= '1;
            r_head   <= '0;
            r_empty  <= 1'b1;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_head   <= n_head;
            r_empty  <= n_empty;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_cur      <= n_cur;
        r_before   <= n_before;
        r_prev_key <= n_prev_key;
        r_nxt      <= n_nxt;
        r_status   <= n_status;
        if (n_strobe) begin
            r_entries <= w_count_wide[ckle_pkg::ENTRIES_W-1:0];
        end
    end

    assign w_count_wide = ckle_pkg::WIDE_W'(n_count);

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_head     = r_head;
        n_empty    = r_empty;
        n_count    = r_count;
        n_key      = r_key;
        n_slot     = r_slot;
        n_cur      = r_cur;
        n_before   = r_before;
        n_prev_key = r_prev_key;
        n_nxt      = r_nxt;
        n_strobe   = 1'b0;
        n_status   = r_status;
        w_rd_addr  = r_cur;
        w_we       = 1'b0;
        w_wr_addr  = r_slot;
        w_wr_node  = '0;
        case (r_state)
            ckle_pkg::S_IDLE: begin
                if (start) begin
                    n_key = i_key;
                    case (ckle_pkg::t_op'(i_operation))
                        ckle_pkg::OP_ADD: begin
                            if (~|r_free) begin
                                n_strobe = 1'b1;
                                n_status = ckle_pkg::ST_FULL;
                            end else if (r_empty) begin
                                // The first node becomes the head and links to itself.
                                w_we           = 1'b1;
                                w_wr_addr      = w_free_slot;
                                w_wr_node.key  = i_key;
                                w_wr_node.link = w_free_slot;
                                n_head         = w_free_slot;
                                n_empty        = 1'b0;
                                n_free[w_free_slot] = 1'b0;
                                n_count        = r_count + ckle_pkg::CNT_W'(1);
                                n_strobe       = 1'b1;
                                n_status       = ckle_pkg::ST_DONE;
                            end else begin
                                n_slot    = w_free_slot;
                                w_rd_addr = r_head;
                                n_state   = ckle_pkg::S_ADD_LINK;
                            end
                        end
                        ckle_pkg::OP_DELETE: begin
                            if (r_empty) begin
                                n_strobe = 1'b1;
                                n_status = ckle_pkg::ST_MISSING;
                            end else begin
                                n_cur     = r_head;
                                w_rd_addr = r_head;
                                n_state   = ckle_pkg::S_WALK;
                            end
                        end
                        ckle_pkg::OP_CLEAR: begin
                            n_free   = '1;
                            n_head   = '0;
                            n_empty  = 1'b1;
                            n_count  = '0;
                            n_strobe = 1'b1;
                            n_status = ckle_pkg::ST_DONE;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ckle_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ckle_pkg::S_ADD_LINK: begin
                // The new node takes over the head's successor.
                n_prev_key     = w_rd_node.key;
                w_we           = 1'b1;
                w_wr_addr      = r_slot;
                w_wr_node.key  = r_key;
                w_wr_node.link = w_rd_node.link;
                n_state        = ckle_pkg::S_ADD_HEAD;
            end
            ckle_pkg::S_ADD_HEAD: begin
                w_we           = 1'b1;
                w_wr_addr      = r_head;
                w_wr_node.key  = r_prev_key;
                w_wr_node.link = r_slot;
                n_free[r_slot] = 1'b0;
                n_count        = r_count + ckle_pkg::CNT_W'(1);
                n_strobe       = 1'b1;
                n_status       = ckle_pkg::ST_DONE;
                n_state        = ckle_pkg::S_IDLE;
            end
            ckle_pkg::S_WALK: begin
                if (w_rd_node.key == r_key) begin
                    n_free[r_cur] = 1'b1;
                    n_count       = r_count - ckle_pkg::CNT_W'(1);
                    if (w_rd_node.link == r_cur) begin
                        // Only node in the list.
                        n_empty  = 1'b1;
                        n_head   = '0;
                        n_strobe = 1'b1;
                        n_status = ckle_pkg::ST_DONE;
                        n_state  = ckle_pkg::S_IDLE;
                    end else if (r_cur == r_head) begin
                        // Removing the head: walk on to find the last node.
                        n_nxt     = w_rd_node.link;
                        n_cur     = w_rd_node.link;
                        w_rd_addr = w_rd_node.link;
                        n_state   = ckle_pkg::S_LAST;
                    end else begin
                        w_we           = 1'b1;
                        w_wr_addr      = r_before;
                        w_wr_node.key  = r_prev_key;
                        w_wr_node.link = w_rd_node.link;
                        n_strobe       = 1'b1;
                        n_status       = ckle_pkg::ST_DONE;
                        n_state        = ckle_pkg::S_IDLE;
                    end
                end else if (w_rd_node.link == r_head) begin
                    n_strobe = 1'b1;
                    n_status = ckle_pkg::ST_MISSING;
                    n_state  = ckle_pkg::S_IDLE;
                end else begin
                    n_before   = r_cur;
                    n_prev_key = w_rd_node.key;
                    n_cur      = w_rd_node.link;
                    w_rd_addr  = w_rd_node.link;
                end
            end
            ckle_pkg::S_LAST: begin
                if (w_rd_node.link == r_head) begin
                    w_we           = 1'b1;
                    w_wr_addr      = r_cur;
                    w_wr_node.key  = w_rd_node.key;
                    w_wr_node.link = r_nxt;
                    n_head         = r_nxt;
                    n_strobe       = 1'b1;
                    n_status       = ckle_pkg::ST_DONE;
                    n_state        = ckle_pkg::S_IDLE;
                end else begin
                    n_cur     = w_rd_node.link;
                    w_rd_addr = w_rd_node.link;
                end
            end
            default: begin
                n_state = ckle_pkg::S_IDLE;
            end
        endcase
    end

    assign busy      = (r_state != ckle_pkg::S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_entries = r_entries;

    // A result is only ever strobed while the engine is idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while a transaction is still in progress");

    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_count == '0 && (&r_free)))
        else $error("empty list with nodes still allocated");

    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == ckle_pkg::CNT_W'(ckle_pkg::NODE_SLOTS - $countones(r_free)))
        else $error("entry count disagrees with the free map");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == ckle_pkg::OP_CLEAR)
            |=> (o_strobe && o_entries == '0 && o_status == ckle_pkg::ST_DONE))
        else $error("clear did not report an empty list");

    a_write_in_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (busy || start))
        else $error("node memory written outside a transaction");

endmodule
